// ===== hw/rtl/bra_pkg.sv =====
// Shared types and constants for the bitmap run allocator.
package bra_pkg;

  localparam int MAP_BYTES_DEF = 128;
  localparam int UNIT_CAP      = 1024;
  localparam int WORD_W        = 32;
  localparam int WORD_SHIFT    = 5;
  localparam int IDX_W         = 10;
  localparam int LEN_W         = 11;
  localparam int BYTES_W       = 8;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;

  localparam logic [BYTES_W-1:0] BYTES_RESET = 8'd128;

  // register index, taken from paddr[2]
  localparam logic REG_BYTES_IN_USE = 1'b0;

  typedef enum logic [1:0] {
    CMD_FIND  = 2'd0,
    CMD_TEST  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_CLEAR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ACCESS,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RES_FAIL,
    RES_OK,
    RES_TEST,
    RES_HIT
  } res_t;

  typedef struct packed {
    logic load;
    logic rd_first;
    logic scan_step;
    logic clear;
    logic wr;
    logic res_en;
    res_t res;
  } ctl_t;

  typedef struct packed {
    op_t  cmd;
    logic op_ok;
    logic hit;
    logic last_word;
  } sts_t;

endpackage

// ===== hw/rtl/bra_ctrl.sv =====
// Command sequencer for the bitmap run allocator.
module bra_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  bra_pkg::sts_t sts,
  output bra_pkg::ctl_t ctl,
  output logic          busy,
  output logic          done
);
  import bra_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.cmd == CMD_CLEAR || !sts.op_ok) state_next = ST_DONE;
        else if (sts.cmd == CMD_FIND) state_next = ST_SCAN;
        else state_next = ST_ACCESS;
      end
      ST_ACCESS: state_next = ST_DONE;
      ST_SCAN: begin
        if (sts.hit || sts.last_word) state_next = ST_DONE;
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state)
      ST_IDLE: ctl.load = start;
      ST_CHECK: begin
        if (sts.cmd == CMD_CLEAR) begin
          ctl.clear  = 1'b1;
          ctl.res_en = 1'b1;
          ctl.res    = RES_OK;
        end else if (!sts.op_ok) begin
          ctl.res_en = 1'b1;
          ctl.res    = RES_FAIL;
        end else begin
          ctl.rd_first = 1'b1;
        end
      end
      ST_ACCESS: begin
        ctl.res_en = 1'b1;
        if (sts.cmd == CMD_WRITE) begin
          ctl.wr  = 1'b1;
          ctl.res = RES_OK;
        end else begin
          ctl.res = RES_TEST;
        end
      end
      ST_SCAN: begin
        if (sts.hit) begin
          ctl.res_en = 1'b1;
          ctl.res    = RES_HIT;
        end else if (sts.last_word) begin
          ctl.res_en = 1'b1;
          ctl.res    = RES_FAIL;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      ST_DONE: ctl = '0;
      default: ctl = '0;
    endcase
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

endmodule

// ===== hw/rtl/bra_dpath.sv =====
// Datapath: map memory, operand latches, word-wide run search and result registers.
module bra_dpath #(
  parameter int MAP_BYTES = bra_pkg::MAP_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bra_pkg::ctl_t                ctl,
  output bra_pkg::sts_t                sts,
  input  logic [bra_pkg::BYTES_W-1:0]  bytes_in_use,
  input  logic [1:0]                   cmd,
  input  logic [bra_pkg::IDX_W-1:0]    bit_index,
  input  logic [bra_pkg::LEN_W-1:0]    run_length,
  input  logic                         bit_value,
  output logic                         found,
  output logic [bra_pkg::IDX_W-1:0]    start_index,
  output logic                         bit_read
);
  import bra_pkg::*;

  localparam int MAP_BITS = (MAP_BYTES * 8 > UNIT_CAP) ? UNIT_CAP : MAP_BYTES * 8;
  localparam int NW       = (MAP_BITS + WORD_W - 1) / WORD_W;
  localparam int AW       = (NW > 1) ? $clog2(NW) : 1;
  localparam int POS_W    = WORD_SHIFT + 1;

  // latched operands
  op_t              cmd_r;
  logic [IDX_W-1:0] idx_r;
  logic [LEN_W-1:0] len_r;
  logic             val_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= op_t'(cmd);
      idx_r <= bit_index;
      len_r <= run_length;
      val_r <= bit_value;
    end
  end

  // units in use
  logic [LEN_W-1:0] byte_units;
  logic [LEN_W-1:0] units;
  logic [LEN_W-1:0] units_m1;
  logic [AW-1:0]    last_idx;
  logic             op_ok;

  assign byte_units = {bytes_in_use, 3'b000};
  assign units      = (byte_units > LEN_W'(MAP_BITS)) ? LEN_W'(MAP_BITS) : byte_units;
  assign units_m1   = units - 1'b1;
  assign last_idx   = units_m1[WORD_SHIFT +: AW];

  always_comb begin
    unique case (cmd_r)
      CMD_FIND:  op_ok = (len_r != '0) && (len_r <= units);
      CMD_TEST:  op_ok = ({1'b0, idx_r} < units);
      CMD_WRITE: op_ok = ({1'b0, idx_r} < units);
      CMD_CLEAR: op_ok = 1'b1;
      default:   op_ok = 1'b0;
    endcase
  end

  // map memory, one word per 32 units; valid bits stand in for the zero fill
  logic [WORD_W-1:0] mem [NW];
  logic [NW-1:0]     vld;
  logic [WORD_W-1:0] rdata;
  logic              rvld;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;
  logic              re;
  logic [AW-1:0]     cnt;
  logic [WORD_W-1:0] word;

  assign waddr = idx_r[WORD_SHIFT +: AW];
  assign re    = ctl.rd_first | ctl.scan_step;

  always_comb begin
    if (ctl.rd_first) begin
      raddr = (cmd_r == CMD_FIND) ? '0 : waddr;
    end else begin
      raddr = cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) mem[waddr] <= wdata;
    if (re) begin
      rdata <= mem[raddr];
      rvld  <= vld[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.clear) begin
      vld <= '0;
    end else if (ctl.wr) begin
      vld[waddr] <= 1'b1;
    end
  end

  assign word = rvld ? rdata : '0;

  always_comb begin
    wdata = word;
    wdata[idx_r[WORD_SHIFT-1:0]] = val_r;
  end

  // run search over one word
  logic [LEN_W-1:0]  run_in;
  logic [LEN_W-1:0]  run_out;
  logic [LEN_W-1:0]  lim;
  logic [LEN_W-1:0]  need;
  logic [WORD_W-1:0] mw;
  logic [POS_W-1:0]  lpos  [WORD_W];
  logic [POS_W-1:0]  lprev [WORD_W];
  logic [WORD_W-1:0] hit_v;
  logic              hit;
  logic [WORD_SHIFT-1:0] hit_pos;
  logic [LEN_W-1:0]  hit_start;

  assign lim  = units - (LEN_W'(cnt) << WORD_SHIFT);
  assign need = (len_r > run_in) ? (len_r - run_in) : '0;

  always_comb begin
    // units past the end look used
    for (int j = 0; j < WORD_W; j++) begin
      mw[j] = word[j] | (LEN_W'(j) >= lim);
    end
    // lpos[j]: position+1 of the highest used bit at or below j, 0 if none
    for (int j = 0; j < WORD_W; j++) begin
      lpos[j] = mw[j] ? POS_W'(j + 1) : '0;
    end
    for (int lvl = 0; lvl < WORD_SHIFT; lvl++) begin
      lprev = lpos;
      for (int j = 0; j < WORD_W; j++) begin
        if (j >= (1 << lvl) && lprev[j] == '0) lpos[j] = lprev[j - (1 << lvl)];
      end
    end
    for (int j = 0; j < WORD_W; j++) begin
      if (lpos[j] == '0) begin
        hit_v[j] = !mw[j] && (LEN_W'(j + 1) >= need);
      end else begin
        hit_v[j] = !mw[j] && (LEN_W'(POS_W'(j + 1) - lpos[j]) >= len_r);
      end
    end
    hit_pos = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (hit_v[j]) hit_pos = WORD_SHIFT'(j);
    end
  end

  assign hit       = |hit_v;
  assign hit_start = (LEN_W'(cnt) << WORD_SHIFT) + LEN_W'(hit_pos) + 1'b1 - len_r;
  assign run_out   = (lpos[WORD_W-1] == '0) ? (run_in + LEN_W'(WORD_W))
                                             : LEN_W'(POS_W'(WORD_W) - lpos[WORD_W-1]);

  always_ff @(posedge clk) begin
    if (ctl.rd_first) begin
      cnt    <= '0;
      run_in <= '0;
    end else if (ctl.scan_step) begin
      cnt    <= cnt + 1'b1;
      run_in <= run_out;
    end
  end

  assign sts.cmd       = cmd_r;
  assign sts.op_ok     = op_ok;
  assign sts.hit       = hit;
  assign sts.last_word = (cnt == last_idx);

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      found       <= 1'b0;
      start_index <= '0;
      bit_read    <= 1'b0;
    end else if (ctl.res_en) begin
      unique case (ctl.res)
        RES_FAIL: begin
          found       <= 1'b0;
          start_index <= '0;
          bit_read    <= 1'b0;
        end
        RES_OK: begin
          found       <= 1'b1;
          start_index <= '0;
          bit_read    <= 1'b0;
        end
        RES_TEST: begin
          found       <= 1'b1;
          start_index <= '0;
          bit_read    <= word[idx_r[WORD_SHIFT-1:0]];
        end
        RES_HIT: begin
          found       <= 1'b1;
          start_index <= hit_start[IDX_W-1:0];
          bit_read    <= 1'b0;
        end
        default: begin
          found       <= 1'b0;
          start_index <= '0;
          bit_read    <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/bitmap_run_allocator_top.sv =====
// Top level of the first-fit bitmap run allocator with its register port.
//
// Usage: raise start with cmd, bit_index, run_length and bit_value while busy
// is low; the word is taken at that edge and busy rises on the next cycle.
// Commands: find a free run of run_length units, test one unit, write one
// unit, clear the whole map. One result word comes back per command, on
// found/start_index/bit_read, valid for the single cycle in which done is
// high; the receiver has no way to stall it and must take it then.
// Sequence: clear and rejected commands go from the check state straight to
// done; test and write pass through the access state; find walks the map
// words of 32 units (at most 32), one word per cycle through the single read
// port of the map memory, until a hit or the last word. busy drops the
// cycle after done; a new command can be taken once busy is low.
// bytes_in_use (address 0) limits the map to its first bytes; write it only
// while busy is low. Reset frees every unit at once and sets bytes_in_use
// to 128; the block accepts a command in the first cycle after reset.
module bitmap_run_allocator_top #(
  parameter int MAP_BYTES = bra_pkg::MAP_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bra_pkg::PADDR_W-1:0]  paddr,
  input  logic [bra_pkg::PDATA_W-1:0]  pwdata,
  output logic [bra_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   cmd,
  input  logic [bra_pkg::IDX_W-1:0]    bit_index,
  input  logic [bra_pkg::LEN_W-1:0]    run_length,
  input  logic                         bit_value,
  output logic                         done,
  output logic                         found,
  output logic [bra_pkg::IDX_W-1:0]    start_index,
  output logic                         bit_read
);
  import bra_pkg::*;

  logic [BYTES_W-1:0] bytes_in_use;
  logic               reg_sel;
  ctl_t               ctl;
  sts_t               sts;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_BYTES_IN_USE);

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_in_use <= BYTES_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      bytes_in_use <= pwdata[BYTES_W-1:0];
    end
  end

  assign prdata = reg_sel ? PDATA_W'(bytes_in_use) : '0;

  bra_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  bra_dpath #(
    .MAP_BYTES (MAP_BYTES)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .bytes_in_use (bytes_in_use),
    .cmd          (cmd),
    .bit_index    (bit_index),
    .run_length   (run_length),
    .bit_value    (bit_value),
    .found        (found),
    .start_index  (start_index),
    .bit_read     (bit_read)
  );

endmodule
